>>> rtl/ftt_pkg.sv
// ---------------------------------------------------------------------------
// ftt_pkg: shared types and constants of the twiddle table generator
// Holds the CORDIC arctangent table, fixed Q30 constants, the CSR register
// indexes and the struct passed from cell to cell.
// ---------------------------------------------------------------------------
`default_nettype none
package ftt_pkg;

   localparam int CORDIC_ITERS = 30;
   localparam int ZW           = 33;   // angle accumulator width, Q2.30 signed
   localparam int XW           = 33;   // x/y datapath width, Q30 signed

   localparam logic signed [XW-1:0] Q30_ONE  = 33'sd1073741824;
   localparam logic signed [XW-1:0] Q30_GAIN = 33'sd652032874;
   localparam logic [31:0]          Q30_HALF_PI = 32'd1686629713;

   // register indexes
   localparam logic [0:0] CSR_SIZE_LOG2 = 1'd0;
   localparam logic [0:0] CSR_MODE      = 1'd1;

   // result source selection
   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_COS  = 2'd1;
   localparam logic [1:0] SEL_SIN  = 2'd2;

   // control carried alongside the datapath
   typedef struct packed {
      logic       valid;     // a transfer occupies this cell
      logic       idx_ok;    // index inside table
      logic       zero_ang;  // angle zero: exact cos 1, sin 0
      logic [1:0] sel;       // which output to take
      logic       half;      // apply 0.5 factor
   } ctl_type;

   typedef struct packed {
      ctl_type                  ctl;
      logic signed [XW-1:0]     x;
      logic signed [XW-1:0]     y;
      logic signed [ZW-1:0]     z;
   } cell_type;

   // atan(2^-i) in Q30, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = 33'sd843314857;
         5'd1:  r = 33'sd497837829;
         5'd2:  r = 33'sd263043837;
         5'd3:  r = 33'sd133525159;
         5'd4:  r = 33'sd67021687;
         5'd5:  r = 33'sd33543516;
         5'd6:  r = 33'sd16775851;
         5'd7:  r = 33'sd8388437;
         5'd8:  r = 33'sd4194283;
         5'd9:  r = 33'sd2097149;
         5'd10: r = 33'sd1048576;
         5'd11: r = 33'sd524288;
         5'd12: r = 33'sd262144;
         5'd13: r = 33'sd131072;
         5'd14: r = 33'sd65536;
         5'd15: r = 33'sd32768;
         5'd16: r = 33'sd16384;
         5'd17: r = 33'sd8192;
         5'd18: r = 33'sd4096;
         5'd19: r = 33'sd2048;
         5'd20: r = 33'sd1024;
         5'd21: r = 33'sd512;
         5'd22: r = 33'sd256;
         5'd23: r = 33'sd128;
         5'd24: r = 33'sd64;
         5'd25: r = 33'sd32;
         5'd26: r = 33'sd16;
         5'd27: r = 33'sd8;
         5'd28: r = 33'sd4;
         5'd29: r = 33'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ftt_cordic_cell.sv
// ---------------------------------------------------------------------------
// ftt_cordic_cell: one CORDIC rotation step
// Rotates the vector by +/- atan(2^-STAGE) and registers the result for
// the next cell of the chain.
// ---------------------------------------------------------------------------
`default_nettype none
module ftt_cordic_cell
   import ftt_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cell_type cell_in,
   output cell_type      cell_out
);

   localparam logic [4:0] STAGE_IDX = 5'(STAGE);
   localparam logic signed [ZW-1:0] ANG = atan_q30(STAGE_IDX);

   cell_type cell_ff, cell_in_d;
   logic signed [XW-1:0] dx, dy;

   // arithmetic shift rounds toward minus infinity
   assign dx = cell_in.y >>> STAGE;
   assign dy = cell_in.x >>> STAGE;

   // rotate toward zero residual angle; drop the transfer under reset
   always_comb begin
      cell_in_d = cell_in;
      if (!cell_in.z[ZW-1]) begin
         cell_in_d.x = cell_in.x - dx;
         cell_in_d.y = cell_in.y + dy;
         cell_in_d.z = cell_in.z - ANG;
      end else begin
         cell_in_d.x = cell_in.x + dx;
         cell_in_d.y = cell_in.y - dy;
         cell_in_d.z = cell_in.z + ANG;
      end
      if (reset) begin
         cell_in_d.ctl.valid = 1'b0;
      end
   end

   // hand the step to the neighbor
   always_ff @(posedge clock) begin
      cell_ff <= cell_in_d;
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

>>> rtl/ftt_index_decode.sv
// ---------------------------------------------------------------------------
// ftt_index_decode: table index to CORDIC start vector
// Splits the index into twiddle and cosine parts, forms the quarter-turn
// phase, scales it to Q2.30 radians and registers the start of the chain.
// ---------------------------------------------------------------------------
`default_nettype none
module ftt_index_decode
   import ftt_pkg::*;
#(
   parameter int MAX_SIZE_LOG2 = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] index,
   input  wire logic [4:0]  size_log2,
   input  wire logic        mode,
   output cell_type         cell_out
);

   localparam logic [4:0] MAX_L = 5'(MAX_SIZE_LOG2);

   logic [4:0]  l_eff;
   logic [4:0]  nc_log2;
   logic [20:0] nw, nc, nch, k, kk;
   logic [16:0] p, e, q;
   logic [32:0] phase;
   logic        ok, zero_ang, half;
   logic [1:0]  sel;
   logic [64:0] prod;
   logic [32:0] zrad;
   cell_type    s0_ff;
   cell_type    s1_ff, s1_in;
   logic [32:0] phase_ff;

   // clamp the size and derive table bounds
   always_comb begin
      l_eff = size_log2;
      if (l_eff < 5'd2) l_eff = 5'd2;
      if (l_eff > MAX_L) l_eff = MAX_L;
      nw      = 21'd1 << (l_eff - 5'd2);
      nc_log2 = mode ? l_eff : (l_eff - 5'd2);
      nc      = 21'd1 << nc_log2;
      nch     = nc >> 1;
      q       = 17'(nw >> 2);
      k       = {4'd0, index} - nw;
      kk      = nc - k;
      p       = 17'(index >> 1);
      e       = '0;
      // reverse p over (L-3) bits
      for (int b = 0; b < 17; b++) begin
         if (5'(b) < l_eff - 5'd3) e[5'(l_eff - 5'd4) - 5'(b)] = p[b];
      end
   end

   // pick phase and output selection
   always_comb begin
      ok = ({4'd0, index} < nw + nc);
      phase = '0;
      sel = SEL_ZERO;
      half = 1'b0;
      if (!ok) begin
         sel = SEL_ZERO;
      end else if ({4'd0, index} < nw) begin
         if (nw > 21'd2) begin
            sel = index[0] ? SEL_SIN : SEL_COS;
            if (e <= q) phase = 33'(e) << (6'd35 - 6'(l_eff));
            else        phase = 33'(e - q) << (6'd36 - 6'(l_eff));
         end
      end else if (nc > 21'd1) begin
         if (k == 21'd0) begin
            sel = SEL_COS; phase = 33'd1 << 31;
         end else if (k == nch) begin
            sel = SEL_COS; half = 1'b1; phase = 33'd1 << 31;
         end else if (k < nch) begin
            sel = SEL_COS; half = 1'b1; phase = 33'(k) << (6'd32 - 6'(nc_log2));
         end else begin
            sel = SEL_SIN; half = 1'b1; phase = 33'(kk) << (6'd32 - 6'(nc_log2));
         end
      end
      zero_ang = (phase == 33'd0);
   end

   // register decoded phase
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.ctl.valid <= 1'b0;
      end else begin
         s0_ff.ctl.valid <= start;
      end
      s0_ff.ctl.idx_ok   <= ok;
      s0_ff.ctl.zero_ang <= zero_ang;
      s0_ff.ctl.sel      <= sel;
      s0_ff.ctl.half     <= half;
      s0_ff.x            <= '0;
      s0_ff.y            <= '0;
      s0_ff.z            <= '0;
      phase_ff           <= phase;
   end

   // scale phase to radians: one 33x32 multiply
   assign prod = {32'd0, phase_ff} * {33'd0, Q30_HALF_PI} + (65'd1 << 31);
   assign zrad = prod[64:32];

   always_comb begin
      s1_in   = s0_ff;
      s1_in.x = Q30_GAIN;
      s1_in.y = '0;
      s1_in.z = $signed(zrad);
      if (reset) begin
         s1_in.ctl.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign cell_out = s1_ff;

endmodule
`default_nettype wire

>>> rtl/fft_twiddle_table_generator.sv
// ---------------------------------------------------------------------------
// fft_twiddle_table_generator: split-radix FFT/DCT coefficient table entry
// Maps a table index to one cosine/sine coefficient via a chain of CORDIC
// cells.
//
//   channel | ports                              | handshake
//   request | req_table_index                    | start & !busy
//   result  | rsp_coef_value, rsp_index_valid    | rsp_strobe, one cycle
//   config  | csr_write, csr_index, csr_data     | csr_write
//
// One index is taken every cycle; busy is never raised. Each result passes
// two decode/scale stages, 30 CORDIC cells and one output stage after its
// transfer. Reset clears the registers to size 10, mode 0 and empties the
// chain. The receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none
module fft_twiddle_table_generator
   import ftt_pkg::*;
#(
   parameter int MAX_SIZE_LOG2 = 16,
   parameter int FRAC_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [16:0] req_table_index,
   output logic             rsp_strobe,
   output logic [16:0]      rsp_coef_value,
   output logic             rsp_index_valid,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [4:0]  csr_data
);

   localparam int SH = 30 - FRAC_BITS;

   logic [4:0] size_ff;
   logic       mode_ff;
   cell_type   chain [0:CORDIC_ITERS];
   logic signed [XW-1:0] cs, sn, pick;
   logic [30:0] mag, rnd;
   logic [16:0] coef_in;
   logic        strobe_ff;
   logic [16:0] coef_ff;
   logic        ok_ff;

   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 5'd10;
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SIZE_LOG2: size_ff <= csr_data;
            CSR_MODE:      mode_ff <= csr_data[0];
            default:       ;
         endcase
      end
   end

   ftt_index_decode #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_decode (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .index     (req_table_index),
      .size_log2 (size_ff),
      .mode      (mode_ff),
      .cell_out  (chain[0])
   );

   // rotation chain
   for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
      ftt_cordic_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // clamp, halve and round to output precision
   always_comb begin
      cs = chain[CORDIC_ITERS].x;
      sn = chain[CORDIC_ITERS].y;
      if (chain[CORDIC_ITERS].ctl.zero_ang) begin
         cs = Q30_ONE;
         sn = '0;
      end
      pick = (chain[CORDIC_ITERS].ctl.sel == SEL_SIN) ? sn : cs;
      if (pick[XW-1])          mag = '0;
      else if (pick > Q30_ONE) mag = 31'(Q30_ONE);
      else                     mag = 31'(pick);
      if (chain[CORDIC_ITERS].ctl.half) mag = mag >> 1;
      if (SH == 0) rnd = mag;
      else         rnd = (mag + 31'((64'd1 << SH) >> 1)) >> SH;
      coef_in = 17'(rnd);
      if (chain[CORDIC_ITERS].ctl.sel == SEL_ZERO || !chain[CORDIC_ITERS].ctl.idx_ok)
         coef_in = '0;
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain[CORDIC_ITERS].ctl.valid;
      end
      coef_ff   <= coef_in;
      ok_ff     <= chain[CORDIC_ITERS].ctl.idx_ok;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_coef_value  = coef_ff;
   assign rsp_index_valid = ok_ff;

endmodule
`default_nettype wire

>>> tb/tb_fft_twiddle_table_generator.sv
// ---------------------------------------------------------------------------
// tb_fft_twiddle_table_generator: self-checking bench for the coefficient
// table generator
// Walks a table of directed indexes across several table sizes and modes,
// then runs random indexes under changing configurations with sender gaps.
// Each result is checked against a bit-exact CORDIC model or a fixed value.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_fft_twiddle_table_generator;
   import ftt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_LOG2  = 16;
   localparam int OUT_FRAC  = 16;
   localparam int PIPE_LAT  = 33;
   localparam int STALL_MAX = 2000;

   typedef struct packed {
      logic [16:0] coef;
      logic        valid;
   } coef_entry_type;

   typedef struct {
      logic [4:0]  size;
      logic        mode;
      logic [16:0] index;
      bit          typed;
      logic [16:0] coef;
      logic        valid;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [16:0] req_table_index;
   logic        rsp_strobe;
   logic [16:0] rsp_coef_value;
   logic        rsp_index_valid;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [4:0]  csr_data;

   logic [4:0]     tbl_size;
   logic           tbl_mode;
   coef_entry_type coef_q[$];
   int             err_cnt;
   int             idle_cycles;

   fft_twiddle_table_generator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_table_index(req_table_index), .rsp_strobe(rsp_strobe),
      .rsp_coef_value(rsp_coef_value), .rsp_index_valid(rsp_index_valid),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // atan(2^-i) in Q30 from its power series, summed in Q60; atan(1) is a constant
   function automatic longint atan_step(input int i);
      longint unsigned acc;
      longint unsigned term;
      int k;
      acc = 0;
      if (i == 0) return 64'd843314857;
      for (k = 0; i * (2 * k + 1) <= 60; k++) begin
         term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
         if (k % 2 == 0) acc = acc + term;
         else acc = acc - term;
      end
      return longint'((acc + (64'd1 << 29)) >> 30);
   endfunction

   // rotate the gain vector by a quarter-turn fraction (Q0.32)
   task automatic rotate(input longint unsigned phase, output longint cs,
                         output longint sn);
      longint x, y, z, dx, dy;
      int i;
      x = 652032874;
      y = 0;
      if (phase > (64'd1 << 32)) phase = 64'd1 << 32;
      if (phase == 0) begin
         cs = 64'd1 << 30;
         sn = 0;
         return;
      end
      z = longint'((phase * 64'd1686629713 + (64'd1 << 31)) >> 32);
      for (i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_step(i);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_step(i);
         end
      end
      cs = x;
      sn = y;
   endtask

   function automatic longint unsigned sat_q30(input longint v);
      if (v < 0) return 0;
      if (v > (64'sd1 << 30)) return 64'd1 << 30;
      return longint'(v);
   endfunction

   function automatic logic [16:0] q30_to_coef(input longint unsigned v);
      return 17'((v + (64'd1 << (29 - OUT_FRAC))) >> (30 - OUT_FRAC));
   endfunction

   function automatic int eff_log2(input logic [4:0] sz);
      if (sz < 2) return 2;
      if (sz > TOP_LOG2) return TOP_LOG2;
      return sz;
   endfunction

   function automatic int table_len(input logic [4:0] sz, input logic md);
      int l;
      l = eff_log2(sz);
      return (1 << (l - 2)) + (md ? (1 << l) : (1 << (l - 2)));
   endfunction

   // table entry for an index under the current size and mode
   task automatic table_entry(input logic [16:0] idx, output coef_entry_type r);
      int l, nc_log2, b;
      longint unsigned nw, nc, nch, k, e, q, p, ph;
      longint cs, sn;
      l = eff_log2(tbl_size);
      nw = 64'd1 << (l - 2);
      nc_log2 = tbl_mode ? l : l - 2;
      nc = 64'd1 << nc_log2;
      r.coef = '0;
      r.valid = 1'b1;
      if (idx >= nw + nc) begin
         r.valid = 1'b0;
      end else if (idx < nw) begin
         if (nw > 2) begin
            p = idx >> 1;
            e = 0;
            for (b = 0; b < l - 3; b++) begin
               e = (e << 1) | (p & 1);
               p = p >> 1;
            end
            q = nw >> 2;
            ph = (e <= q) ? (e << (35 - l)) : ((e - q) << (36 - l));
            rotate(ph, cs, sn);
            r.coef = q30_to_coef(sat_q30(idx[0] ? sn : cs));
         end
      end else if (nc > 1) begin
         k = idx - nw;
         nch = nc >> 1;
         if (k == 0) begin
            rotate(64'd1 << 31, cs, sn);
            r.coef = q30_to_coef(sat_q30(cs));
         end else if (k == nch) begin
            rotate(64'd1 << 31, cs, sn);
            r.coef = q30_to_coef(sat_q30(cs) >> 1);
         end else if (k < nch) begin
            rotate(k << (32 - nc_log2), cs, sn);
            r.coef = q30_to_coef(sat_q30(cs) >> 1);
         end else begin
            rotate((nc - k) << (32 - nc_log2), cs, sn);
            r.coef = q30_to_coef(sat_q30(sn) >> 1);
         end
      end
   endtask

   // check each result against the oldest pending entry
   always @(posedge clock) begin
      coef_entry_type want;
      if (!reset && rsp_strobe) begin
         if (coef_q.size() == 0) begin
            $display("%0t: unexpected result coef=%0d valid=%0b", $time,
                     rsp_coef_value, rsp_index_valid);
            err_cnt++;
         end else begin
            want = coef_q.pop_front();
            if (rsp_coef_value !== want.coef) begin
               $display("%0t: coef_value expected %0d actual %0d", $time,
                        want.coef, rsp_coef_value);
               err_cnt++;
            end
            if (rsp_index_valid !== want.valid) begin
               $display("%0t: index_valid expected %0b actual %0b", $time,
                        want.valid, rsp_index_valid);
               err_cnt++;
            end
         end
      end
   end

   // watchdog: count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_MAX) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (coef_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 3) @(posedge clock);
   endtask

   // write the size register, then the mode register, back to back
   task automatic write_config(input logic [4:0] size, input logic mode);
      csr_write <= 1'b1;
      csr_index <= CSR_SIZE_LOG2;
      csr_data  <= size;
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_data  <= {4'd0, mode};
      @(posedge clock);
      csr_write <= 1'b0;
      tbl_size = size;
      tbl_mode = mode;
   endtask

   // hold start until the transfer is taken, then queue its entry
   task automatic send_index(input logic [16:0] idx, input bit typed,
                             input coef_entry_type fixed);
      coef_entry_type r;
      start <= 1'b1;
      req_table_index <= idx;
      do @(posedge clock); while (busy);
      if (typed) r = fixed;
      else table_entry(idx, r);
      coef_q.push_back(r);
   endtask

   task automatic pause_sender(input int pct);
      int gap;
      gap = ($urandom_range(99) < pct) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   vector_type vectors[] = '{
      '{5'd10, 1'b0, 17'd0,      1, 17'd65536, 1'b1},
      '{5'd10, 1'b0, 17'd1,      1, 17'd0,     1'b1},
      '{5'd10, 1'b0, 17'd255,    0, 17'd0,     1'b0},
      '{5'd10, 1'b0, 17'd256,    0, 17'd0,     1'b0},
      '{5'd10, 1'b0, 17'd384,    0, 17'd0,     1'b0},
      '{5'd10, 1'b0, 17'd511,    0, 17'd0,     1'b0},
      '{5'd10, 1'b0, 17'd512,    1, 17'd0,     1'b0},
      '{5'd10, 1'b0, 17'd131071, 1, 17'd0,     1'b0},
      '{5'd2,  1'b0, 17'd0,      1, 17'd0,     1'b1},
      '{5'd2,  1'b0, 17'd1,      1, 17'd0,     1'b1},
      '{5'd2,  1'b0, 17'd2,      1, 17'd0,     1'b0},
      '{5'd0,  1'b1, 17'd1,      0, 17'd0,     1'b0},
      '{5'd0,  1'b1, 17'd3,      0, 17'd0,     1'b0},
      '{5'd0,  1'b1, 17'd4,      0, 17'd0,     1'b0},
      '{5'd0,  1'b1, 17'd5,      1, 17'd0,     1'b0},
      '{5'd3,  1'b0, 17'd0,      1, 17'd0,     1'b1},
      '{5'd3,  1'b0, 17'd1,      1, 17'd0,     1'b1},
      '{5'd16, 1'b1, 17'd0,      1, 17'd65536, 1'b1},
      '{5'd16, 1'b1, 17'd16383,  0, 17'd0,     1'b0},
      '{5'd16, 1'b1, 17'd49152,  0, 17'd0,     1'b0},
      '{5'd16, 1'b1, 17'd81919,  0, 17'd0,     1'b0},
      '{5'd16, 1'b1, 17'd81920,  1, 17'd0,     1'b0},
      '{5'd31, 1'b0, 17'd32767,  0, 17'd0,     1'b0},
      '{5'd31, 1'b0, 17'd32768,  1, 17'd0,     1'b0}
   };

   logic [4:0] phase_sizes[] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd7, 5'd12};
   int         phase_idle[]  = '{0, 65, 29, 65, 0, 29};

   initial begin
      coef_entry_type fixed;
      int n, ph, len;
      logic [16:0] idx;
      reset = 1'b1;
      start = 1'b0;
      req_table_index = '0;
      csr_write = 1'b0;
      csr_index = CSR_SIZE_LOG2;
      csr_data = '0;
      tbl_size = 5'd10;
      tbl_mode = 1'b0;
      err_cnt = 0;
      idle_cycles = 0;
      fixed = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, reconfigured whenever a row asks for new settings
      foreach (vectors[i]) begin
         if (vectors[i].size != tbl_size || vectors[i].mode != tbl_mode) begin
            start <= 1'b0;
            @(posedge clock);
            wait_drained();
            write_config(vectors[i].size, vectors[i].mode);
         end
         fixed.coef = vectors[i].coef;
         fixed.valid = vectors[i].valid;
         send_index(vectors[i].index, vectors[i].typed, fixed);
      end

      // random phases: new settings, then indexes mostly inside the table
      for (ph = 0; ph < phase_sizes.size(); ph++) begin
         start <= 1'b0;
         @(posedge clock);
         wait_drained();
         write_config(phase_sizes[ph], 1'($urandom_range(1)));
         len = table_len(tbl_size, tbl_mode);
         for (n = 0; n < 125; n++) begin
            if ($urandom_range(99) < 85) idx = 17'($urandom_range(len - 1));
            else idx = 17'($urandom_range(131071));
            send_index(idx, 0, fixed);
            // hold off until the pipeline is empty once mid-phase
            if (ph == 1 && n == 60) begin
               start <= 1'b0;
               @(posedge clock);
               while (coef_q.size() != 0) @(posedge clock);
            end else begin
               pause_sender(phase_idle[ph]);
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      wait_drained();
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
